[rtl/core/hng_pkg.sv]
// Shared constants and types for the heightmap normal generator.
`timescale 1ns / 1ps
package hng_pkg;
	localparam int HEIGHT_W  = 16;
	localparam int COL_W     = 10;
	localparam int ROW_W     = 16;
	localparam int ABS_W     = 18;
	localparam int SQ_W      = 36;
	localparam int MAG_W     = 15;
	localparam int QDEPTH_W  = 2;
	// squared y component: (2^9)^2
	localparam logic [SQ_W-1:0] AY_SQ = 36'd262144;

	typedef struct packed {
		logic [ABS_W-1:0] ax;
		logic [ABS_W-1:0] az;
		logic             neg_x;
		logic             neg_z;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
		logic             fend;
	} job_t;
endpackage

[rtl/core/hng_queue.sv]
// Short job queue between the slope front end and the normalizer.
`timescale 1ns / 1ps
module hng_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hng_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output hng_pkg::job_t head,
	output logic          empty
);
	hng_pkg::job_t                  slot_q [4];
	logic [hng_pkg::QDEPTH_W-1:0]   wp_q, rp_q;
	logic [hng_pkg::QDEPTH_W:0]     cnt_q;

	assign full  = (cnt_q == 3'd4);
	assign empty = (cnt_q == 3'd0);
	assign head  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) slot_q[wp_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= wp_q + 2'd1;
			if (pop && !empty) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, push && !full} - {2'd0, pop && !empty};
		end
	end
endmodule

[rtl/core/hng_front.sv]
// Front end: line store, raster counters and slope extraction per normal.
`timescale 1ns / 1ps
module hng_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [hng_pkg::HEIGHT_W-1:0] sample,
	input  logic                        restart,
	input  logic [hng_pkg::COL_W-1:0]   cols,
	input  logic [hng_pkg::ROW_W-1:0]   rows,
	output logic                        push,
	output hng_pkg::job_t               job,
	input  logic                        q_full
);
	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_RD   = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [hng_pkg::HEIGHT_W-1:0] mem [0:3071];
	logic [hng_pkg::HEIGHT_W-1:0] rd_q;
	logic [hng_pkg::HEIGHT_W-1:0] h_q [4];
	logic [1:0]  fst_q, sel_q, rot_q, srot_q;
	logic [2:0]  step_q, en_q;
	logic [hng_pkg::ROW_W-1:0] row_q, r_q;
	logic [hng_pkg::COL_W-1:0] col_q, c_q;

	logic        acc;
	logic [2:0]  en_new;
	logic [hng_pkg::ROW_W-1:0] pr;
	logic [hng_pkg::COL_W-1:0] pc, xhi, xlo, rcol;
	logic [1:0]  bpr, zlo_b, rback, next_sel;
	logic        dblx, dblz, has_next;
	logic [11:0] raddr;
	logic signed [16:0] dxr, dzr;
	logic signed [17:0] dx, dz;

	function automatic logic [1:0] slot_of(input logic [1:0] rot, input logic [1:0] back);
		logic [1:0] s;
		case (back)
			2'd0:    s = rot;
			2'd1:    s = (rot == 2'd0) ? 2'd2 : rot - 2'd1;
			default: s = (rot == 2'd2) ? 2'd0 : rot + 2'd1;
		endcase
		return s;
	endfunction

	assign s_tready = (fst_q == F_IDLE);
	assign acc      = s_tvalid && s_tready;

	assign en_new[0] = (row_q != '0);
	assign en_new[1] = (row_q == rows) && (col_q != '0);
	assign en_new[2] = (row_q == rows) && (col_q == cols);

	always_comb begin
		pr  = (sel_q == 2'd0) ? r_q - 16'd1 : rows;
		pc  = (sel_q == 2'd0) ? c_q : ((sel_q == 2'd1) ? c_q - 10'd1 : cols);
		bpr = (sel_q == 2'd0) ? 2'd1 : 2'd0;
		if (pc == '0) begin
			xhi = 10'd1; xlo = 10'd0; dblx = 1'b1;
		end else if (pc == cols) begin
			xhi = cols; xlo = cols - 10'd1; dblx = 1'b1;
		end else begin
			xhi = pc + 10'd1; xlo = pc - 10'd1; dblx = 1'b0;
		end
		dblz  = (pr == '0) || (pr == rows);
		zlo_b = dblz ? 2'd1 : 2'd2;
		case (step_q)
			3'd0:    begin rback = bpr;   rcol = xhi; end
			3'd1:    begin rback = bpr;   rcol = xlo; end
			3'd2:    begin rback = 2'd0;  rcol = pc;  end
			default: begin rback = zlo_b; rcol = pc;  end
		endcase
		raddr = {slot_of(srot_q, rback), rcol};
		dxr = $signed({h_q[0][15], h_q[0]}) - $signed({h_q[1][15], h_q[1]});
		dzr = $signed({h_q[2][15], h_q[2]}) - $signed({h_q[3][15], h_q[3]});
		dx  = dblx ? {dxr, 1'b0} : {dxr[16], dxr};
		dz  = dblz ? {dzr, 1'b0} : {dzr[16], dzr};
		has_next = 1'b0;
		next_sel = sel_q;
		if (sel_q == 2'd0 && en_q[1]) begin
			has_next = 1'b1; next_sel = 2'd1;
		end else if (sel_q != 2'd2 && en_q[2]) begin
			has_next = 1'b1; next_sel = 2'd2;
		end
		job.ax    = dx[17] ? 18'(-dx) : 18'(dx);
		job.az    = dz[17] ? 18'(-dz) : 18'(dz);
		job.neg_x = !dx[17] && (dx != '0);
		job.neg_z = !dz[17] && (dz != '0);
		job.row   = pr;
		job.col   = pc;
		job.last  = !has_next;
		job.fend  = (pr == rows) && (pc == cols);
	end

	assign push = (fst_q == F_PUSH) && !q_full;

	always_ff @(posedge clk) begin
		if (acc) mem[{rot_q, col_q}] <= sample;
		rd_q <= mem[raddr];
		if (fst_q == F_RD && step_q != 3'd0) h_q[step_q[1:0] - 2'd1] <= rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= F_IDLE; sel_q <= '0; step_q <= '0; en_q <= '0;
			row_q <= '0; col_q <= '0; rot_q <= '0; srot_q <= '0;
			r_q <= '0; c_q <= '0;
		end else if (restart) begin
			row_q <= '0; col_q <= '0; rot_q <= '0;
		end else begin
			case (fst_q)
				F_IDLE: if (acc) begin
					r_q <= row_q; c_q <= col_q; srot_q <= rot_q; en_q <= en_new;
					step_q <= '0;
					if (en_new[0]) begin
						sel_q <= 2'd0; fst_q <= F_RD;
					end else if (en_new[1]) begin
						sel_q <= 2'd1; fst_q <= F_RD;
					end else if (en_new[2]) begin
						sel_q <= 2'd2; fst_q <= F_RD;
					end
					// advance raster position
					if (col_q >= cols) begin
						col_q <= '0;
						if (row_q >= rows) begin
							row_q <= '0; rot_q <= '0;
						end else begin
							row_q <= row_q + 16'd1;
							rot_q <= (rot_q == 2'd2) ? 2'd0 : rot_q + 2'd1;
						end
					end else begin
						col_q <= col_q + 10'd1;
					end
				end
				F_RD: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4) fst_q <= F_PUSH;
				end
				F_PUSH: if (!q_full) begin
					step_q <= '0;
					sel_q  <= next_sel;
					fst_q  <= has_next ? F_RD : F_IDLE;
				end
				default: fst_q <= F_IDLE;
			endcase
		end
	end
endmodule

[rtl/core/hng_back.sv]
// Back end: iterative normalization of slope vectors into unit normals.
`timescale 1ns / 1ps
module hng_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  hng_pkg::job_t head,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [79:0]   m_tdata,
	output logic          m_tlast,
	output logic          m_tuser
);
	localparam logic [2:0] B_IDLE  = 3'd0;
	localparam logic [2:0] B_SQX   = 3'd1;
	localparam logic [2:0] B_SQZ   = 3'd2;
	localparam logic [2:0] B_SUM   = 3'd3;
	localparam logic [2:0] B_DINIT = 3'd4;
	localparam logic [2:0] B_DIV   = 3'd5;
	localparam logic [2:0] B_SQRT  = 3'd6;
	localparam logic [2:0] B_OUT   = 3'd7;

	hng_pkg::job_t            job_q;
	logic [2:0]               bst_q;
	logic [hng_pkg::SQ_W-1:0] sqx_q, sqz_q, s_q, a2;
	logic [36:0]              rem_q, sh;
	logic [30:0]              quot_q, quot_nx, x_q, res_q, bit_q, trial, res_nx;
	logic [4:0]               cnt_q;
	logic [1:0]               comp_q;
	logic [hng_pkg::MAG_W-1:0] mag_q [3];
	logic [hng_pkg::MAG_W-1:0] mag_nx, ny;
	logic [15:0]              nx, nz;
	logic                     take;

	assign pop  = (bst_q == B_IDLE) && !q_empty;
	assign take = !m_tvalid || m_tready;

	always_comb begin
		case (comp_q)
			2'd0:    a2 = sqx_q;
			2'd1:    a2 = hng_pkg::AY_SQ;
			default: a2 = sqz_q;
		endcase
		sh      = {rem_q[35:0], 1'b0};
		quot_nx = {quot_q[29:0], sh >= {1'b0, s_q}};
		trial   = res_q + bit_q;
		res_nx  = (x_q >= trial) ? (res_q >> 1) + bit_q : res_q >> 1;
		mag_nx  = hng_pkg::MAG_W'((res_nx + 31'd1) >> 1);
		ny      = (mag_q[1] == '0) ? 15'd1 : mag_q[1];
		nx      = job_q.neg_x ? 16'(-{1'b0, mag_q[0]}) : {1'b0, mag_q[0]};
		nz      = job_q.neg_z ? 16'(-{1'b0, mag_q[2]}) : {1'b0, mag_q[2]};
	end

	always_ff @(posedge clk) begin
		case (bst_q)
			B_IDLE:  if (!q_empty) job_q <= head;
			B_SQX:   sqx_q <= job_q.ax * job_q.ax;
			B_SQZ:   sqz_q <= job_q.az * job_q.az;
			B_SUM:   s_q <= sqx_q + sqz_q + hng_pkg::AY_SQ;
			B_DINIT: begin
				cnt_q <= '0;
				if (a2 >= s_q) begin
					rem_q <= {1'b0, a2 - s_q}; quot_q <= 31'd1;
				end else begin
					rem_q <= {1'b0, a2}; quot_q <= '0;
				end
			end
			B_DIV: begin
				cnt_q  <= cnt_q + 5'd1;
				quot_q <= quot_nx;
				rem_q  <= (sh >= {1'b0, s_q}) ? sh - {1'b0, s_q} : sh;
				x_q    <= quot_nx;
				res_q  <= '0;
				bit_q  <= 31'h4000_0000;
			end
			B_SQRT: begin
				if (x_q >= trial) x_q <= x_q - trial;
				res_q <= res_nx;
				bit_q <= bit_q >> 2;
				if (bit_q == 31'd1) mag_q[comp_q] <= mag_nx;
			end
			default: ;
		endcase
		if (bst_q == B_OUT && take) begin
			m_tdata <= {7'd0, job_q.col, job_q.row, nz, ny, nx};
			m_tlast <= job_q.last;
			m_tuser <= job_q.fend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q    <= B_IDLE;
			comp_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (bst_q == B_OUT && take) m_tvalid <= 1'b1;
			else if (m_tready)          m_tvalid <= 1'b0;
			case (bst_q)
				B_IDLE:  if (!q_empty) bst_q <= B_SQX;
				B_SQX:   bst_q <= B_SQZ;
				B_SQZ:   bst_q <= B_SUM;
				B_SUM:   begin comp_q <= '0; bst_q <= B_DINIT; end
				B_DINIT: bst_q <= B_DIV;
				B_DIV:   if (cnt_q == 5'd29) bst_q <= B_SQRT;
				B_SQRT:  if (bit_q == 31'd1) begin
					comp_q <= comp_q + 2'd1;
					bst_q  <= (comp_q == 2'd2) ? B_OUT : B_DINIT;
				end
				B_OUT:   if (take) bst_q <= B_IDLE;
				default: bst_q <= B_IDLE;
			endcase
		end
	end
endmodule

[rtl/core/heightmap_normal_generation.sv]
// Top level of the heightmap normal generator: config registers and block wiring.
`timescale 1ns / 1ps
// Heights arrive in raster order, one per transaction; normals leave one row
// behind. The front end takes a sample when it is free and then releases the
// normals that the sample completes, each with four line-store reads through
// the single read port plus a push; a sample in the first row releases none,
// one in a later row releases one, and one on the last row up to three. The
// normalizer takes one normal at a time (three 30-step divisions and three
// 16-step square roots in one shared unit), which sets the sustained rate; a
// four-entry queue sits between them. Any register write restarts the frame.
module heightmap_normal_generation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // height_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // normal_x, normal_y, normal_z, point_row, point_col
	output logic        m_tlast,   // run_last
	output logic        m_tuser,   // frame_end
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [9:0]  cols_q;
	logic [15:0] rows_q;
	logic        wr, q_full, q_empty, push, pop;
	logic [9:0]  cols_eff;
	logic [15:0] rows_eff;
	hng_pkg::job_t push_job, head;

	assign pready   = 1'b1;
	assign wr       = psel && penable && pwrite;
	assign prdata   = paddr[2] ? {16'd0, rows_q} : {22'd0, cols_q};
	assign cols_eff = (cols_q == '0) ? 10'd1 : cols_q;
	assign rows_eff = (rows_q == '0) ? 16'd1 : rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 10'd1;
			rows_q <= 16'd1;
		end else if (wr) begin
			if (paddr[2]) rows_q <= pwdata[15:0];
			else          cols_q <= pwdata[9:0];
		end
	end

	hng_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .sample(s_tdata), .restart(wr),
		.cols(cols_eff), .rows(rows_eff), .push, .job(push_job), .q_full
	);

	hng_queue u_queue (
		.clk, .arst_n, .push, .push_job, .full(q_full), .pop, .head, .empty(q_empty)
	);

	hng_back u_back (
		.clk, .arst_n, .q_empty, .head, .pop, .m_tvalid, .m_tready, .m_tdata,
		.m_tlast, .m_tuser
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("job pushed into full queue");
	a_fend_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast) else $error("frame end not last of run");
	a_ny_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[30:16] != 15'd0) else $error("normal_y is zero");
endmodule
